// ----- sv/lgl_pkg.sv -----
// Shared types, constants and the arctangent table for the grid to latitude/longitude core.
`default_nettype none
package lgl_pkg;

  typedef struct packed {
    logic [31:0] point_easting;
    logic [31:0] point_northing;
  } point_t;

  typedef struct packed {
    logic signed [30:0] latitude_out;
    logic signed [31:0] longitude_out;
    logic               longitude_saturated;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic [61:0]        magx;
    logic [61:0]        magy;
    logic               sx;
    logic               sy;
  } cordic_t;

  localparam logic [2:0] REG_REF_EASTING   = 3'd0;
  localparam logic [2:0] REG_REF_NORTHING  = 3'd1;
  localparam logic [2:0] REG_REF_LATITUDE  = 3'd2;
  localparam logic [2:0] REG_REF_LONGITUDE = 3'd3;
  localparam logic [2:0] REG_SPHERE_RADIUS = 3'd4;

  localparam logic [29:0] DEG_PER_RAD_E7 = 30'd572957795;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;
  localparam logic signed [31:0] LAT_LIMIT = 32'sd900000000;
  localparam logic [22:0] R_MIN = 23'd6000000;
  localparam logic [22:0] R_MAX = 23'd6500000;
  localparam logic [22:0] R_RESET = 23'd6371000;
  localparam int CORDIC_STAGES = 30;
  localparam int DIV_STAGES = 33;

  function automatic logic signed [31:0] atan_e7(input int i);
    logic signed [31:0] a;
    case (i)
      0: a = 32'sd450000000;
      1: a = 32'sd265650512;
      2: a = 32'sd140362435;
      3: a = 32'sd71250163;
      4: a = 32'sd35763344;
      5: a = 32'sd17899106;
      6: a = 32'sd8951737;
      7: a = 32'sd4476142;
      8: a = 32'sd2238105;
      9: a = 32'sd1119057;
      10: a = 32'sd559529;
      11: a = 32'sd279765;
      12: a = 32'sd139882;
      13: a = 32'sd69941;
      14: a = 32'sd34971;
      15: a = 32'sd17485;
      16: a = 32'sd8743;
      17: a = 32'sd4371;
      18: a = 32'sd2186;
      19: a = 32'sd1093;
      20: a = 32'sd546;
      21: a = 32'sd273;
      22: a = 32'sd137;
      23: a = 32'sd68;
      24: a = 32'sd34;
      25: a = 32'sd17;
      26: a = 32'sd9;
      27: a = 32'sd4;
      28: a = 32'sd2;
      29: a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- sv/lgl_cordic_cell.sv -----
// One rotation step of the cosine CORDIC, registered, carrying the offsets alongside.
`default_nettype none
module lgl_cordic_cell #(
  parameter int SHIFT = 0,
  parameter logic signed [31:0] ATAN = 32'sd0
) (
  input  wire              clk,
  input  wire              rst,
  input  lgl_pkg::cordic_t st_in,
  output lgl_pkg::cordic_t st_out
);
  import lgl_pkg::*;

  logic signed [32:0] xs;
  logic signed [32:0] ys;
  cordic_t st_next;

  always_comb begin
    xs = st_in.x >>> SHIFT;
    ys = st_in.y >>> SHIFT;
    st_next = st_in;
    if (!st_in.z[31]) begin
      st_next.x = st_in.x - ys;
      st_next.y = st_in.y + xs;
      st_next.z = st_in.z - ATAN;
    end else begin
      st_next.x = st_in.x + ys;
      st_next.y = st_in.y - xs;
      st_next.z = st_in.z + ATAN;
    end
    if (rst) begin
      st_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_out <= st_next;
  end
endmodule
`default_nettype wire

// ----- sv/lgl_div_cell.sv -----
// One quotient bit of a pipelined restoring divider.
`default_nettype none
module lgl_div_cell #(
  parameter int DW = 31,
  parameter int K = 33,
  parameter int TW = 1
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           valid_in,
  input  wire [DW-1:0]  den_in,
  input  wire [DW-1:0]  rem_in,
  input  wire [K-1:0]   bits_in,
  input  wire [K-1:0]   q_in,
  input  wire [TW-1:0]  tag_in,
  output logic          valid_out,
  output logic [DW-1:0] den_out,
  output logic [DW-1:0] rem_out,
  output logic [K-1:0]  bits_out,
  output logic [K-1:0]  q_out,
  output logic [TW-1:0] tag_out
);
  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem_in, bits_in[K-1]};
    diff = trial - {1'b0, den_in};
    ge = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    den_out <= den_in;
    rem_out <= ge ? diff[DW-1:0] : trial[DW-1:0];
    bits_out <= {bits_in[K-2:0], 1'b0};
    q_out <= {q_in[K-2:0], ge};
    tag_out <= tag_in;
  end
endmodule
`default_nettype wire

// ----- sv/local_grid_to_latlon_approx_core.sv -----
// Top level of the grid offset to latitude/longitude converter.
//   channel  direction  handshake        payload
//   command  in         start / busy     point (point_t)
//   result   out        done strobe      result (result_t)
//   config   in         wr_en            wr_index, wr_data
// A transaction is taken every cycle; busy is always low.
// Results appear one per accepted command, in order.
// The pipeline runs through the 30-cell cosine CORDIC row and the two 33-cell divider rows.
// Reset clears the valid bits and loads the register reset values; the receiver cannot stall.
`default_nettype none
module local_grid_to_latlon_approx_core (
  input  wire             clk,
  input  wire             rst,
  input  wire             start,
  output logic            busy,
  input  lgl_pkg::point_t point,
  output logic            done,
  output lgl_pkg::result_t result,
  input  wire             wr_en,
  input  wire [2:0]       wr_index,
  input  wire [31:0]      wr_data
);
  import lgl_pkg::*;

  logic [31:0] ref_easting;
  logic [31:0] ref_northing;
  logic [30:0] ref_latitude;
  logic [31:0] ref_longitude;
  logic [22:0] sphere_radius_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_easting <= '0;
      ref_northing <= '0;
      ref_latitude <= '0;
      ref_longitude <= '0;
      sphere_radius_m <= R_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_REF_EASTING: ref_easting <= wr_data;
        REG_REF_NORTHING: ref_northing <= wr_data;
        REG_REF_LATITUDE: ref_latitude <= wr_data[30:0];
        REG_REF_LONGITUDE: ref_longitude <= wr_data;
        REG_SPHERE_RADIUS: sphere_radius_m <= wr_data[22:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic signed [31:0] rlat;
  logic signed [31:0] rlat_raw;
  logic [22:0]        rad;
  logic [30:0]        dval;

  always_comb begin
    rlat_raw = 32'($signed(ref_latitude));
    if (rlat_raw > LAT_LIMIT) begin
      rlat = LAT_LIMIT;
    end else if (rlat_raw < -LAT_LIMIT) begin
      rlat = -LAT_LIMIT;
    end else begin
      rlat = rlat_raw;
    end
    if (sphere_radius_m < R_MIN) begin
      rad = R_MIN;
    end else if (sphere_radius_m > R_MAX) begin
      rad = R_MAX;
    end else begin
      rad = sphere_radius_m;
    end
    dval = {rad, 8'd0};
  end

  logic        v1;
  point_t      pt1;
  logic        v2;
  logic [31:0] absdx;
  logic [31:0] absdy;
  logic        sx2;
  logic        sy2;
  logic [32:0] dx;
  logic [32:0] dy;

  assign dx = {1'b0, pt1.point_easting} - {1'b0, ref_easting};
  assign dy = {1'b0, pt1.point_northing} - {1'b0, ref_northing};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
    end
    pt1 <= point;
    sx2 <= dx[32];
    sy2 <= dy[32];
    absdx <= dx[32] ? 32'(-dx) : dx[31:0];
    absdy <= dy[32] ? 32'(-dy) : dy[31:0];
  end

  cordic_t cs [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cs[0].valid <= 1'b0;
    end else begin
      cs[0].valid <= v2;
    end
    cs[0].x <= CORDIC_START;
    cs[0].y <= '0;
    cs[0].z <= rlat;
    cs[0].magx <= 62'(absdx) * 62'(DEG_PER_RAD_E7);
    cs[0].magy <= 62'(absdy) * 62'(DEG_PER_RAD_E7);
    cs[0].sx <= sx2;
    cs[0].sy <= sy2;
  end

  genvar gi;
  generate
    for (gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cordic
      lgl_cordic_cell #(
        .SHIFT(gi),
        .ATAN(atan_e7(gi))
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .st_in(cs[gi]),
        .st_out(cs[gi+1])
      );
    end
  endgenerate

  cordic_t     cf;
  logic [30:0] cosv;

  assign cf = cs[CORDIC_STAGES];

  always_comb begin
    if (cf.x[32]) begin
      cosv = '0;
    end else if (cf.x > Q30_ONE) begin
      cosv = 31'(Q30_ONE);
    end else begin
      cosv = cf.x[30:0];
    end
  end

  logic        v4;
  logic [60:0] den4;
  logic [62:0] latnum4;
  logic [61:0] magx4;
  logic        sx4;
  logic        sy4;
  logic        pole4;
  logic [61:0] prod4;

  assign prod4 = 62'(dval) * 62'(cosv);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= cf.valid;
    end
    den4 <= prod4[60:0];
    latnum4 <= 63'(cf.magy) + 63'(dval >> 1);
    magx4 <= cf.magx;
    sx4 <= cf.sx;
    sy4 <= cf.sy;
    pole4 <= cosv < 31'd2;
  end

  logic [91:0] numx;
  assign numx = {magx4, 30'd0} + 92'(den4 >> 1);

  logic        lv [DIV_STAGES+1];
  logic [60:0] lden [DIV_STAGES+1];
  logic [60:0] lrem [DIV_STAGES+1];
  logic [32:0] lbits [DIV_STAGES+1];
  logic [32:0] lq [DIV_STAGES+1];
  logic [3:0]  ltag [DIV_STAGES+1];
  logic        av [DIV_STAGES+1];
  logic [30:0] aden [DIV_STAGES+1];
  logic [30:0] arem [DIV_STAGES+1];
  logic [32:0] abits [DIV_STAGES+1];
  logic [32:0] aq [DIV_STAGES+1];
  logic [0:0]  atag [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else begin
      lv[0] <= v4;
    end
    lden[0] <= den4;
    lrem[0] <= 61'(numx[91:33]);
    lbits[0] <= numx[32:0];
    lq[0] <= '0;
    ltag[0] <= {sx4, sy4, pole4, {2'b00, numx[91:33]} >= den4};
    av[0] <= v4;
    aden[0] <= dval;
    arem[0] <= 31'(latnum4[62:33]);
    abits[0] <= latnum4[32:0];
    aq[0] <= '0;
    atag[0] <= 1'b0;
  end

  generate
    for (gi = 0; gi < DIV_STAGES; gi++) begin : g_div
      lgl_div_cell #(.DW(61), .K(33), .TW(4)) u_lon (
        .clk(clk), .rst(rst),
        .valid_in(lv[gi]), .den_in(lden[gi]), .rem_in(lrem[gi]),
        .bits_in(lbits[gi]), .q_in(lq[gi]), .tag_in(ltag[gi]),
        .valid_out(lv[gi+1]), .den_out(lden[gi+1]), .rem_out(lrem[gi+1]),
        .bits_out(lbits[gi+1]), .q_out(lq[gi+1]), .tag_out(ltag[gi+1])
      );
      lgl_div_cell #(.DW(31), .K(33), .TW(1)) u_lat (
        .clk(clk), .rst(rst),
        .valid_in(av[gi]), .den_in(aden[gi]), .rem_in(arem[gi]),
        .bits_in(abits[gi]), .q_in(aq[gi]), .tag_in(atag[gi]),
        .valid_out(av[gi+1]), .den_out(aden[gi+1]), .rem_out(arem[gi+1]),
        .bits_out(abits[gi+1]), .q_out(aq[gi+1]), .tag_out(atag[gi+1])
      );
    end
  endgenerate

  logic               fsx;
  logic               fsy;
  logic               fpole;
  logic               fovf;
  logic signed [34:0] lat_off;
  logic signed [34:0] lat_sum;
  logic signed [34:0] lon_off;
  logic signed [34:0] lon_sum;
  result_t            result_next;

  always_comb begin
    fsx = ltag[DIV_STAGES][3];
    fsy = ltag[DIV_STAGES][2];
    fpole = ltag[DIV_STAGES][1];
    fovf = ltag[DIV_STAGES][0];
    lat_off = fsy ? -$signed({2'b00, aq[DIV_STAGES]}) : $signed({2'b00, aq[DIV_STAGES]});
    lat_sum = 35'(rlat) + lat_off;
    if (lat_sum > 35'(LAT_LIMIT)) begin
      result_next.latitude_out = 31'(LAT_LIMIT);
    end else if (lat_sum < -35'(LAT_LIMIT)) begin
      result_next.latitude_out = 31'(-LAT_LIMIT);
    end else begin
      result_next.latitude_out = lat_sum[30:0];
    end
    if (fpole) begin
      lon_off = '0;
    end else if (fsx) begin
      lon_off = -$signed({2'b00, lq[DIV_STAGES]});
    end else begin
      lon_off = $signed({2'b00, lq[DIV_STAGES]});
    end
    lon_sum = 35'($signed(ref_longitude)) + lon_off;
    result_next.longitude_saturated = 1'b1;
    if (!fpole && fovf) begin
      result_next.longitude_out = fsx ? 32'sh80000000 : 32'sh7fffffff;
    end else if (lon_sum > 35'sd2147483647) begin
      result_next.longitude_out = 32'sh7fffffff;
    end else if (lon_sum < -35'sd2147483648) begin
      result_next.longitude_out = 32'sh80000000;
    end else begin
      result_next.longitude_out = lon_sum[31:0];
      result_next.longitude_saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= lv[DIV_STAGES];
    end
    result <= result_next;
  end

`ifndef SYNTH
  a_lat_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.latitude_out <= 31'sd900000000 && result.latitude_out >= -31'sd900000000))
    else $error("latitude result outside +-90 degrees");
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.longitude_saturated) |->
      (result.longitude_out == 32'sh7fffffff || result.longitude_out == 32'sh80000000))
    else $error("saturated longitude not at a range limit");
  a_rows_aligned: assert property (@(posedge clk) disable iff (rst)
    lv[DIV_STAGES] == av[DIV_STAGES])
    else $error("divider rows out of step");
`endif
endmodule
`default_nettype wire

// ----- verif/local_grid_to_latlon_approx_core_tb.sv -----
// Self-checking testbench for the grid offset to latitude/longitude converter.
`default_nettype none
module local_grid_to_latlon_approx_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgl_pkg::*;

  localparam longint DEG_E7_PER_RAD = 572957795;
  localparam longint LAT_MAX_E7 = 900000000;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  class latlon_scoreboard;
    logic [31:0] ref_e, ref_n, ref_lon;
    logic [30:0] ref_lat;
    logic [22:0] radius;
    result_t expected_q[$];
    int mismatches, checked, saturations, pole_hits;
    longint atan_tab[30] = '{450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
      8951737, 4476142, 2238105, 1119057, 559529, 279765, 139882, 69941, 34971, 17485,
      8743, 4371, 2186, 1093, 546, 273, 137, 68, 34, 17, 9, 4, 2, 1};

    function void reset_regs();
      ref_e = '0;
      ref_n = '0;
      ref_lat = '0;
      ref_lon = '0;
      radius = 23'd6371000;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_REF_EASTING: ref_e = data;
        REG_REF_NORTHING: ref_n = data;
        REG_REF_LATITUDE: ref_lat = data[30:0];
        REG_REF_LONGITUDE: ref_lon = data;
        REG_SPHERE_RADIUS: radius = data[22:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint cosine_q30(longint angle);
      longint x, y, z, xs, ys;
      x = 652032874;
      y = 0;
      z = angle;
      for (int i = 0; i < 30; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      return clamp(x, 0, 64'sd1073741824);
    endfunction

    function void note_point(point_t p);
      longint dx, dy, rlat, rlon, r, lat, lon, lon_off, c;
      longint unsigned d, mag, q, den;
      logic [127:0] num;
      result_t res;
      dx = longint'({32'b0, p.point_easting}) - longint'({32'b0, ref_e});
      dy = longint'({32'b0, p.point_northing}) - longint'({32'b0, ref_n});
      rlat = clamp(longint'(signed'(ref_lat)), -LAT_MAX_E7, LAT_MAX_E7);
      rlon = longint'(signed'(ref_lon));
      r = clamp(longint'({41'b0, radius}), 6000000, 6500000);
      d = r * 256;
      mag = (dy < 0 ? -dy : dy) * DEG_E7_PER_RAD;
      q = (mag + d / 2) / d;
      lat = clamp(rlat + (dy < 0 ? -longint'(q) : longint'(q)), -LAT_MAX_E7, LAT_MAX_E7);
      c = cosine_q30(rlat);
      lon_off = 0;
      if (c >= 2) begin
        den = d * c;
        mag = (dx < 0 ? -dx : dx) * DEG_E7_PER_RAD;
        num = ({64'b0, mag} << 30) + {64'b0, den / 2};
        q = 64'(num / {64'b0, den});
        lon_off = dx < 0 ? -longint'(q) : longint'(q);
      end else begin
        pole_hits++;
      end
      lon = rlon + lon_off;
      res.longitude_saturated = 1'b0;
      if (lon > 64'sd2147483647) begin
        lon = 64'sd2147483647;
        res.longitude_saturated = 1'b1;
      end else if (lon < -64'sd2147483648) begin
        lon = -64'sd2147483648;
        res.longitude_saturated = 1'b1;
      end
      res.latitude_out = lat[30:0];
      res.longitude_out = lon[31:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (got.longitude_saturated) saturations++;
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result mismatch: expected lat %0d lon %0d sat %0b, got lat %0d lon %0d sat %0b",
                   exp_r.latitude_out, exp_r.longitude_out, exp_r.longitude_saturated,
                   got.latitude_out, got.longitude_out, got.longitude_saturated);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  point_t point = '0;
  logic done;
  result_t result;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = '0;
  logic [31:0] wr_data = '0;

  latlon_scoreboard sb = new();
  bit steady_flow = 1'b0;
  int sent_points = 0;
  int config_writes = 0;
  int cycle_count = 0;

  always #4 clk = ~clk;

  local_grid_to_latlon_approx_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done) sb.check_result(result);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    sb.write_reg(idx, data);
    config_writes++;
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic send_point(logic [31:0] e, logic [31:0] n);
    point_t p;
    p.point_easting = e;
    p.point_northing = n;
    @(negedge clk);
    while (!steady_flow && $urandom_range(99) < 20) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    point <= p;
    forever begin
      @(posedge clk);
      if (!busy) break;
      @(negedge clk);
    end
    sb.note_point(p);
    sent_points++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_near(int count, int span);
    int off_e, off_n;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(3) == 0) begin
        send_point($urandom, $urandom);
      end else begin
        off_e = int'($urandom_range(2 * span)) - span;
        off_n = int'($urandom_range(2 * span)) - span;
        send_point(sb.ref_e + off_e, sb.ref_n + off_n);
      end
    end
  endtask

  initial begin
    int lat_pick[6];
    lat_pick = '{900000000, -900000000, 32'h3FFFFFFF, 32'h40000000, 0, 899999999};
    sb.reset_regs();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_point(32'h0, 32'h0);
    send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_point(32'hFFFFFFFF, 32'h0);
    send_point(32'h0, 32'hFFFFFFFF);
    send_point(32'h12345678, 32'h87654321);
    drain();

    write_reg(REG_REF_EASTING, 32'h80000000);
    write_reg(REG_REF_NORTHING, 32'h80000000);
    write_reg(REG_REF_LATITUDE, 32'd900000000);
    write_reg(REG_REF_LONGITUDE, 32'h7FFFFFFF);
    write_reg(REG_SPHERE_RADIUS, 32'd0);
    write_reg(3'd5, 32'hFFFFFFFF);
    write_reg(3'd7, 32'h0);
    send_point(32'h80000000, 32'h80000000);
    send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_point(32'h0, 32'h0);
    drain();

    write_reg(REG_REF_LATITUDE, 32'h3FFFFFFF);
    write_reg(REG_REF_LONGITUDE, 32'h80000000);
    write_reg(REG_SPHERE_RADIUS, 32'h7FFFFF);
    send_point(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_point(32'h0, 32'h0);
    drain();

    write_reg(REG_REF_LATITUDE, 32'hC0000000);
    write_reg(REG_REF_LONGITUDE, -32'sd1800000000);
    write_reg(REG_SPHERE_RADIUS, 32'd6000000);
    send_point(32'h0, 32'h0);
    send_point(32'hFFFFFFFF, 32'h7FFFFFFF);
    drain();

    write_reg(REG_REF_LATITUDE, 32'd899999999);
    write_reg(REG_REF_LONGITUDE, 32'd1800000000);
    write_reg(REG_SPHERE_RADIUS, 32'd6500000);
    send_point(32'h0, 32'hFFFFFFFF);
    send_point(32'hFFFFFFFF, 32'h0);
    send_point(32'h80000100, 32'h7FFFFF00);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_REF_EASTING, $urandom);
      write_reg(REG_REF_NORTHING, $urandom);
      write_reg(REG_REF_LATITUDE, (ph < 6 && ph % 2 == 0) ? lat_pick[ph]
                : int'($urandom_range(1800000000)) - 900000000);
      write_reg(REG_REF_LONGITUDE, ph == 3 ? $urandom
                : int'($urandom_range(3600000000)) - 1800000000);
      write_reg(REG_SPHERE_RADIUS, ph == 1 ? 32'd6000000 : ph == 2 ? 32'd6500000
                : ph == 5 ? $urandom : $urandom_range(6500000, 6000000));
      steady_flow = (ph == 4);
      send_near(85, ph % 2 ? 32'h00FFFFFF : 32'h0000FFFF);
      drain();
    end

    $display("Sent %0d points over %0d register writes; %0d results checked.",
             sent_points, config_writes, sb.checked);
    $display("Saturated longitudes: %0d, pole-guarded points: %0d.", sb.saturations,
             sb.pole_hits);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, results still missing: %0d.", sb.mismatches,
               sb.expected_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
